FILE: src/bbc_pkg.sv
package bbc_pkg;

  localparam int ENTRIES_DEF = 32;

  localparam int DEV_W   = 8;
  localparam int BLK_W   = 32;
  localparam int SLOT_W  = 5;
  localparam int REFC_W  = 8;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_GET     = 2'd0,
    CMD_WRITE   = 2'd1,
    CMD_RELEASE = 2'd2,
    CMD_DONE    = 2'd3
  } cmd_e_t;

  localparam logic [STAT_W-1:0] ST_HIT   = 2'd0;
  localparam logic [STAT_W-1:0] ST_NEW   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_UNDER = 2'd3;

  localparam logic [REFC_W-1:0] REFC_MAX = '1;

  // One table entry as it sits in the tag memory.
  typedef struct packed {
    logic [DEV_W-1:0]  dev;
    logic [BLK_W-1:0]  blk;
    logic [REFC_W-1:0] refc;
    logic              vld;
    logic              drt;
  } entry_t;

  // One result item as handed from the controller to the output register.
  typedef struct packed {
    logic [SLOT_W-1:0] result_slot;
    logic [STAT_W-1:0] status;
    logic              need_disk_read;
    logic              need_disk_write;
  } result_t;

endpackage

FILE: src/bbc_if.sv
interface bbc_req_if
  import bbc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  cmd;
  logic [DEV_W-1:0]  device_id;
  logic [BLK_W-1:0]  block_number;
  logic [SLOT_W-1:0] slot;

  modport source (output valid, cmd, device_id, block_number, slot, input ready);
  modport sink   (input valid, cmd, device_id, block_number, slot, output ready);
endinterface

interface bbc_rsp_if
  import bbc_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] result_slot;
  logic [STAT_W-1:0] status;
  logic              need_disk_read;
  logic              need_disk_write;

  modport source (output valid, result_slot, status, need_disk_read, need_disk_write,
                  input ready);
  modport sink   (input valid, result_slot, status, need_disk_read, need_disk_write,
                  output ready);
endinterface

FILE: src/bbc_tag_mem.sv
module bbc_tag_mem
  import bbc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output entry_t                     rd_data,
  input  logic                       wr_en,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  entry_t                     wr_data
);

  entry_t               mem [ENTRIES];
  entry_t               mem_q;
  logic [ENTRIES-1:0]   written;
  logic                 written_q;

  // An entry never written since reset reads as all zeros.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written   <= '0;
      written_q <= 1'b0;
    end else begin
      if (wr_en) begin
        written[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        written_q <= written[rd_addr];
      end
    end
  end

  assign rd_data = written_q ? mem_q : '0;

endmodule

FILE: src/bbc_ctrl.sv
module bbc_ctrl
  import bbc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  bbc_req_if.sink                    req,
  output logic                       mem_rd_en,
  output logic [$clog2(ENTRIES)-1:0] mem_rd_addr,
  input  entry_t                     mem_rd_data,
  output logic                       mem_wr_en,
  output logic [$clog2(ENTRIES)-1:0] mem_wr_addr,
  output entry_t                     mem_wr_data,
  input  logic                       res_free,
  output logic                       res_push,
  output result_t                    res
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_RMW    = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  state_t            state, state_next;
  cmd_e_t            cmd_q;
  logic [DEV_W-1:0]  dev_q;
  logic [BLK_W-1:0]  blk_q;
  logic [IDX_W-1:0]  slot_q;
  logic [IDX_W-1:0]  chk, chk_next;
  logic              hit_found, hit_found_next;
  logic [IDX_W-1:0]  hit_idx, hit_idx_next;
  entry_t            hit_ent, hit_ent_next;
  logic              free_found, free_found_next;
  logic [IDX_W-1:0]  free_idx, free_idx_next;
  result_t           res_next;
  logic              accept;
  logic              slot_ok;
  logic              is_match;
  logic              is_free;
  entry_t            ent;

  assign req.ready = (state == S_IDLE);
  assign accept    = req.valid && req.ready;
  assign slot_ok   = 32'(req.slot) < 32'(ENTRIES);
  assign is_match  = (mem_rd_data.dev == dev_q) && (mem_rd_data.blk == blk_q);
  assign is_free   = (mem_rd_data.refc == '0) && !mem_rd_data.drt;

  always_comb begin
    state_next      = state;
    chk_next        = chk;
    hit_found_next  = hit_found;
    hit_idx_next    = hit_idx;
    hit_ent_next    = hit_ent;
    free_found_next = free_found;
    free_idx_next   = free_idx;
    res_next        = res;
    res_push        = 1'b0;
    mem_rd_en       = 1'b0;
    mem_rd_addr     = '0;
    mem_wr_en       = 1'b0;
    mem_wr_addr     = '0;
    mem_wr_data     = '0;
    ent             = mem_rd_data;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if (cmd_e_t'(req.cmd) == CMD_GET) begin
            mem_rd_en       = 1'b1;
            mem_rd_addr     = '0;
            chk_next        = '0;
            hit_found_next  = 1'b0;
            free_found_next = 1'b0;
            state_next      = S_SCAN;
          end else if (slot_ok) begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = IDX_W'(req.slot);
            state_next  = S_RMW;
          end else begin
            res_next   = '{result_slot: req.slot, status: ST_HIT,
                           need_disk_read: 1'b0, need_disk_write: 1'b0};
            state_next = S_RESULT;
          end
        end
      end

      S_SCAN: begin
        // Data on the read port belongs to entry chk; the next read goes out now.
        if (chk != LAST_IDX) begin
          mem_rd_en   = 1'b1;
          mem_rd_addr = chk + 1'b1;
        end
        if (is_match && !hit_found) begin
          hit_found_next = 1'b1;
          hit_idx_next   = chk;
          hit_ent_next   = mem_rd_data;
        end
        if (is_free && !free_found) begin
          free_found_next = 1'b1;
          free_idx_next   = chk;
        end
        chk_next = chk + 1'b1;
        if (chk == LAST_IDX) begin
          state_next = S_DECIDE;
        end
      end

      S_DECIDE: begin
        if (hit_found) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = hit_idx;
          mem_wr_data = hit_ent;
          if (hit_ent.refc != REFC_MAX) begin
            mem_wr_data.refc = hit_ent.refc + 1'b1;
          end
          res_next = '{result_slot: SLOT_W'(hit_idx), status: ST_HIT,
                       need_disk_read: !hit_ent.vld, need_disk_write: 1'b0};
        end else if (free_found) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = free_idx;
          mem_wr_data = '{dev: dev_q, blk: blk_q, refc: REFC_W'(1), vld: 1'b0, drt: 1'b0};
          res_next = '{result_slot: SLOT_W'(free_idx), status: ST_NEW,
                       need_disk_read: 1'b1, need_disk_write: 1'b0};
        end else begin
          res_next = '{result_slot: '0, status: ST_FULL,
                       need_disk_read: 1'b0, need_disk_write: 1'b0};
        end
        state_next = S_RESULT;
      end

      S_RMW: begin
        res_next = '{result_slot: SLOT_W'(slot_q), status: ST_HIT,
                     need_disk_read: 1'b0, need_disk_write: 1'b0};
        unique case (cmd_q)
          CMD_WRITE: begin
            ent.drt                  = 1'b1;
            mem_wr_en                = 1'b1;
            res_next.need_disk_write = 1'b1;
          end
          CMD_RELEASE: begin
            if (mem_rd_data.refc == '0) begin
              res_next.status = ST_UNDER;
            end else begin
              ent.refc  = mem_rd_data.refc - 1'b1;
              mem_wr_en = 1'b1;
            end
          end
          CMD_DONE: begin
            ent.vld   = 1'b1;
            ent.drt   = 1'b0;
            mem_wr_en = 1'b1;
          end
          CMD_GET: begin
          end
        endcase
        mem_wr_addr = slot_q;
        mem_wr_data = ent;
        state_next  = S_RESULT;
      end

      S_RESULT: begin
        if (res_free) begin
          res_push   = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_e_t'(req.cmd);
      dev_q  <= req.device_id;
      blk_q  <= req.block_number;
      slot_q <= IDX_W'(req.slot);
    end
    chk        <= chk_next;
    hit_found  <= hit_found_next;
    hit_idx    <= hit_idx_next;
    hit_ent    <= hit_ent_next;
    free_found <= free_found_next;
    free_idx   <= free_idx_next;
    res        <= res_next;
  end

endmodule

FILE: src/block_buffer_cache_tags.sv
// Tag table of a disk block buffer cache.
// Commands arrive as items on the req channel (valid/ready); each command
// yields exactly one result item on the rsp channel, in order. A get looks up
// device and block number, taking a reference on a hit or claiming the lowest
// entry with no references that is not dirty. Write, release and done act on
// the addressed slot.
// A get occupies the block while it sweeps every entry of the tag memory
// through its single read port, one per cycle, then writes back the hit or
// claimed entry, if any, and hands off the result. Write, release and done
// go through read, modify and write, then hand-off; an out-of-range slot goes
// straight to hand-off. The result appears on rsp in the cycle after the
// hand-off, from the output register.
// The rsp side is registered, so a new item is accepted while an earlier
// result still waits. If the receiver stalls, the next result is held in the
// controller and req stays not ready until the output register frees up.
// Reset clears the controller, the output register and the per-entry written
// bits; an entry never written reads as all zeros, matching a zeroed table.
module block_buffer_cache_tags
  import bbc_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  bbc_req_if.sink    req,
  bbc_rsp_if.source  rsp
);

  localparam int IDX_W = $clog2(ENTRIES);

  logic             mem_rd_en;
  logic [IDX_W-1:0] mem_rd_addr;
  entry_t           mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  entry_t           mem_wr_data;
  logic             res_free;
  logic             res_push;
  result_t          res;
  logic             out_valid, out_valid_next;
  result_t          out_item;

  bbc_tag_mem #(.ENTRIES(ENTRIES)) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  bbc_ctrl #(.ENTRIES(ENTRIES)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .mem_rd_en   (mem_rd_en),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data),
    .res_free    (res_free),
    .res_push    (res_push),
    .res         (res)
  );

  // The output register takes a new result when empty or being drained.
  assign res_free       = !out_valid || rsp.ready;
  assign out_valid_next = res_push || (out_valid && !rsp.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      out_item <= res;
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.result_slot     = out_item.result_slot;
  assign rsp.status          = out_item.status;
  assign rsp.need_disk_read  = out_item.need_disk_read;
  assign rsp.need_disk_write = out_item.need_disk_write;

endmodule

FILE: src/bbc_checker.sv
module bbc_checker
  import bbc_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              req_valid,
  input logic              req_ready,
  input logic              rsp_valid,
  input logic              rsp_ready,
  input logic [SLOT_W-1:0] result_slot,
  input logic [STAT_W-1:0] status,
  input logic              need_disk_read,
  input logic              need_disk_write
);

  // A stalled result stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result withdrawn while stalled");

  // Every command is processed alone, so ready drops after an accept.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("command accepted while another is in flight");

  // A full table reports slot zero and asks for no read.
  a_full_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> result_slot == '0 && !need_disk_read)
    else $error("no-free-buffer result carries stray fields");

  // A fresh allocation always needs its data read; a write request never does.
  a_flag_combo: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (status != ST_NEW || need_disk_read) &&
                  (!need_disk_write || (status == ST_HIT && !need_disk_read)))
    else $error("inconsistent disk request flags");

endmodule

bind block_buffer_cache_tags bbc_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .req_valid       (req.valid),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .result_slot     (rsp.result_slot),
  .status          (rsp.status),
  .need_disk_read  (rsp.need_disk_read),
  .need_disk_write (rsp.need_disk_write)
);
